@@ hdl/fscc_pkg.sv @@
`default_nettype none
package fscc_pkg;

	localparam int MEM_BYTES_DEF = 131072;
	localparam int BANK_BYTES    = 65536;
	localparam int SECTOR_BYTES  = 4096;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int IDX_W  = 17;
	localparam int SEC_W  = $clog2(SECTOR_BYTES);
	localparam int CFG_W  = 2;

	// unlock addresses and data
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 16'h5555;
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 16'h2aaa;
	localparam logic [DATA_W-1:0] DATA_UNLOCK1 = 8'haa;
	localparam logic [DATA_W-1:0] DATA_UNLOCK2 = 8'h55;

	// command bytes
	localparam logic [DATA_W-1:0] CMD_ID_ON     = 8'h90;
	localparam logic [DATA_W-1:0] CMD_ID_OFF    = 8'hf0;
	localparam logic [DATA_W-1:0] CMD_BANK      = 8'hb0;
	localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
	localparam logic [DATA_W-1:0] CMD_CHIP_ERS  = 8'h10;
	localparam logic [DATA_W-1:0] CMD_SEC_ERS   = 8'h30;
	localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'ha0;

	// unlock stages
	localparam logic [1:0] STG_READY = 2'd0;
	localparam logic [1:0] STG_ONE   = 2'd1;
	localparam logic [1:0] STG_TWO   = 2'd2;

	// pending operations
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_BANK    = 2'd1;
	localparam logic [1:0] OP_ERASE   = 2'd2;
	localparam logic [1:0] OP_PROGRAM = 2'd3;

	// register indexes
	localparam logic [CFG_W-1:0] REG_TWO_BANKS = 2'd0;
	localparam logic [CFG_W-1:0] REG_MAN_ID    = 2'd1;
	localparam logic [CFG_W-1:0] REG_DEV_ID    = 2'd2;

	localparam logic [DATA_W-1:0] MAN_ID_RST = 8'h62;
	localparam logic [DATA_W-1:0] DEV_ID_RST = 8'h13;
	localparam logic [DATA_W-1:0] ERASED     = 8'hff;

	typedef struct packed {
		logic                    prog;
		logic                    sec_erase;
		logic                    chip_erase;
		logic [ADDR_W-SEC_W-1:0] sec_base;
		logic                    id_hit;
		logic [DATA_W-1:0]       id_byte;
	} fscc_act_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} fscc_wr_t;

endpackage
`default_nettype wire

@@ hdl/fscc_if.sv @@
`default_nettype none
interface fscc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [fscc_pkg::ADDR_W-1:0] address;
	logic [fscc_pkg::DATA_W-1:0] write_data;
	modport source (output valid, command, address, write_data, input ready);
	modport sink (input valid, command, address, write_data, output ready);
endinterface

interface fscc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fscc_pkg::DATA_W-1:0] read_data;
	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

interface fscc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [fscc_pkg::CFG_W-1:0]  index;
	logic [fscc_pkg::DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/flash_save_command_controller.sv @@
`default_nettype none
// channel  dir  word                           handshake
// req      in   command, address, write_data   valid/ready
// rsp      out  read_data                      valid/ready
// cfg      in   index, data                    valid/ready, ready always high
//
// a write loads a zero result word; a read passes first through the store read
// port register and then into the output register
// a sector erase stalls req until its sector is swept, a chip erase until the whole
// store is swept, one store write port entry per cycle
// after reset the store is swept to 0xff before req is ready
// req is taken while a result waits only if rsp takes that result in the same cycle
module flash_save_command_controller #(
	parameter int MEM_BYTES = fscc_pkg::MEM_BYTES_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fscc_req_if.sink  req,
	fscc_rsp_if.source rsp,
	fscc_cfg_if.sink  cfg
);
	import fscc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic              state_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              rd_id_q;
	logic [DATA_W-1:0] id_byte_q;

	logic              fire, rd_fire, wr_fire;
	logic              sweep_busy;
	logic              bank;
	logic [DATA_W-1:0] mem_data;
	fscc_act_t         act;
	fscc_wr_t          sweep_wr, mem_wr;

	// word accepted only with the sweep idle and the output slot free or draining
	assign req.ready = (state_q == ST_IDLE) && !sweep_busy && (!out_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign wr_fire   = fire && req.command;
	assign rd_fire   = fire && !req.command;
	assign cfg.ready = 1'b1;

	fscc_cmd u_cmd (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.wr_fire    (wr_fire),
		.address    (req.address),
		.write_data (req.write_data),
		.act        (act),
		.bank       (bank)
	);

	fscc_sweep #(.MEM_BYTES(MEM_BYTES)) u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_chip (act.chip_erase),
		.start_sec  (act.sec_erase),
		.sec_base   (act.sec_base),
		.bank       (bank),
		.busy       (sweep_busy),
		.wr         (sweep_wr)
	);

	// sweep owns the write port while busy; programs only happen when it is idle
	always_comb begin
		if (sweep_busy) begin
			mem_wr = sweep_wr;
		end else begin
			mem_wr.en   = act.prog;
			mem_wr.bank = bank;
			mem_wr.addr = req.address;
			mem_wr.data = req.write_data;
		end
	end

	fscc_store #(.MEM_BYTES(MEM_BYTES)) u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_fire),
		.rd_bank (bank),
		.rd_addr (req.address),
		.rd_data (mem_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// a new write word refills the slot as the old one drains
					if (wr_fire)
						out_valid_q <= 1'b1;
					else if (rsp.valid && rsp.ready)
						out_valid_q <= 1'b0;
					if (rd_fire)
						state_q <= ST_READ;
				end
				ST_READ: begin
					// slot is always empty here, the read accept needed it free
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// id bytes are picked at accept, store data in the read state that follows
	always_ff @(posedge clk) begin
		if (rd_fire) begin
			rd_id_q   <= act.id_hit;
			id_byte_q <= act.id_byte;
		end
		if (wr_fire)
			out_data_q <= '0;
		else if (state_q == ST_READ)
			out_data_q <= rd_id_q ? id_byte_q : mem_data;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
endmodule
`default_nettype wire

@@ hdl/fscc_store.sv @@
`default_nettype none
module fscc_store #(
	parameter int MEM_BYTES = fscc_pkg::MEM_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire fscc_pkg::fscc_wr_t          wr,
	input  wire logic                        rd_en,
	input  wire logic                        rd_bank,
	input  wire logic [fscc_pkg::ADDR_W-1:0] rd_addr,
	output logic      [fscc_pkg::DATA_W-1:0] rd_data
);
	import fscc_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [IDX_W-1:0] MEM_LIM = IDX_W'(MEM_BYTES);

	logic [DATA_W-1:0] mem_q [MEM_BYTES];
	logic [DATA_W-1:0] rd_data_q;

	// bank and address fold into the store, wrapping past the end
	function automatic logic [AW-1:0] fold(input logic bank, input logic [ADDR_W-1:0] a);
		logic [IDX_W-1:0] s;
		s = {bank, a};
		if (s >= MEM_LIM)
			s = s - MEM_LIM;
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (wr.en)
			mem_q[fold(wr.bank, wr.addr)] <= wr.data;
		if (rd_en)
			rd_data_q <= mem_q[fold(rd_bank, rd_addr)];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

@@ hdl/fscc_sweep.sv @@
`default_nettype none
module fscc_sweep #(
	parameter int MEM_BYTES = fscc_pkg::MEM_BYTES_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         start_chip,
	input  wire logic                                         start_sec,
	input  wire logic [fscc_pkg::ADDR_W-fscc_pkg::SEC_W-1:0]  sec_base,
	input  wire logic                                         bank,
	output logic                                              busy,
	output fscc_pkg::fscc_wr_t                                wr
);
	import fscc_pkg::*;

	localparam logic [IDX_W-1:0] CHIP_LAST = IDX_W'(MEM_BYTES - 1);
	localparam logic [SEC_W-1:0] SEC_LAST  = SEC_W'(SECTOR_BYTES - 1);

	logic                    busy_q;
	logic                    chip_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [ADDR_W-SEC_W-1:0] base_q;
	logic                    bank_q;
	logic                    last;

	assign last = chip_q ? (cnt_q == CHIP_LAST) : (cnt_q[SEC_W-1:0] == SEC_LAST);

	// reset starts a whole-store clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			chip_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 1'b1;
		end else if (start_chip) begin
			busy_q <= 1'b1;
			chip_q <= 1'b1;
			cnt_q  <= '0;
		end else if (start_sec) begin
			busy_q <= 1'b1;
			chip_q <= 1'b0;
			cnt_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start_sec) begin
			base_q <= sec_base;
			bank_q <= bank;
		end
	end

	always_comb begin
		wr.en   = busy_q;
		wr.data = ERASED;
		if (chip_q) begin
			wr.bank = cnt_q[ADDR_W];
			wr.addr = cnt_q[ADDR_W-1:0];
		end else begin
			wr.bank = bank_q;
			wr.addr = {base_q, cnt_q[SEC_W-1:0]};
		end
	end

	assign busy = busy_q;
endmodule
`default_nettype wire

@@ hdl/fscc_cmd.sv @@
`default_nettype none
module fscc_cmd (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [fscc_pkg::CFG_W-1:0]  cfg_idx,
	input  wire logic [fscc_pkg::DATA_W-1:0] cfg_data,
	input  wire logic                        wr_fire,
	input  wire logic [fscc_pkg::ADDR_W-1:0] address,
	input  wire logic [fscc_pkg::DATA_W-1:0] write_data,
	output fscc_pkg::fscc_act_t              act,
	output logic                             bank
);
	import fscc_pkg::*;

	logic [1:0]        stage_q, stage_n;
	logic [1:0]        pend_q, pend_n;
	logic              id_q, id_n;
	logic              bank_q, bank_n;
	logic              two_banks_q;
	logic [DATA_W-1:0] man_id_q;
	logic [DATA_W-1:0] dev_id_q;
	logic              prog, sec, chip;
	logic              at_u1, at_u2;

	assign at_u1 = (address == ADDR_UNLOCK1);
	assign at_u2 = (address == ADDR_UNLOCK2);

	always_comb begin
		stage_n = stage_q;
		pend_n  = pend_q;
		id_n    = id_q;
		bank_n  = bank_q;
		prog    = 1'b0;
		sec     = 1'b0;
		chip    = 1'b0;
		if (at_u1 && stage_q == STG_READY && write_data == DATA_UNLOCK1) begin
			stage_n = STG_ONE;
		end else if (at_u1 && stage_q == STG_TWO) begin
			stage_n = STG_READY;
			case (write_data)
				CMD_ID_ON:   id_n = 1'b1;
				CMD_ID_OFF:  id_n = 1'b0;
				CMD_BANK:    pend_n = OP_BANK;
				CMD_ERASE:   pend_n = OP_ERASE;
				CMD_PROGRAM: pend_n = OP_PROGRAM;
				CMD_CHIP_ERS: begin
					// without an armed erase the sequence stays in its second stage
					if (pend_q == OP_ERASE) begin
						chip   = 1'b1;
						pend_n = OP_NONE;
					end else begin
						stage_n = STG_TWO;
					end
				end
				CMD_SEC_ERS: begin
					sec    = 1'b1;
					pend_n = OP_NONE;
				end
				default: ;
			endcase
		end else if (at_u2 && stage_q == STG_ONE && write_data == DATA_UNLOCK2) begin
			stage_n = STG_TWO;
		end else begin
			case (pend_q)
				OP_BANK: begin
					if (address == '0) begin
						bank_n = two_banks_q & write_data[0];
						pend_n = OP_NONE;
					end
				end
				OP_PROGRAM: begin
					prog   = 1'b1;
					pend_n = OP_NONE;
				end
				OP_ERASE: begin
					if (write_data == CMD_SEC_ERS && stage_q == STG_TWO) begin
						sec     = 1'b1;
						pend_n  = OP_NONE;
						stage_n = STG_READY;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= STG_READY;
			pend_q      <= OP_NONE;
			id_q        <= 1'b0;
			bank_q      <= 1'b0;
			two_banks_q <= 1'b0;
			man_id_q    <= MAN_ID_RST;
			dev_id_q    <= DEV_ID_RST;
		end else begin
			if (wr_fire) begin
				stage_q <= stage_n;
				pend_q  <= pend_n;
				id_q    <= id_n;
				bank_q  <= bank_n;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_TWO_BANKS: two_banks_q <= cfg_data[0];
					REG_MAN_ID:    man_id_q <= cfg_data;
					REG_DEV_ID:    dev_id_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		act.prog       = wr_fire & prog;
		act.sec_erase  = wr_fire & sec;
		act.chip_erase = wr_fire & chip;
		act.sec_base   = address[ADDR_W-1:SEC_W];
		act.id_hit     = id_q && (address[ADDR_W-1:1] == '0);
		act.id_byte    = address[0] ? dev_id_q : man_id_q;
	end

	assign bank = bank_q;
endmodule
`default_nettype wire

@@ test/flash_save_command_controller_tb.sv @@
`default_nettype none
module flash_save_command_controller_tb;
	import fscc_pkg::*;

	localparam int STORE_BYTES = MEM_BYTES_DEF;

	// access kinds on the req channel
	localparam bit ACC_READ  = 1'b0;
	localparam bit ACC_WRITE = 1'b1;

	// what a write access would wipe, used to keep the run length bounded
	localparam int NO_WIPE     = 0;
	localparam int SECTOR_WIPE = 1;
	localparam int CHIP_WIPE   = 2;

	// random accesses per idling phase
	localparam int PHASE_ACCESSES = 225;
	// long receiver hold-off, in cycles
	localparam int HOLD_CYCLES = 400;

	// shadow copy of the flash chip: store, unlock stage, pending operation,
	// identify mode, bank and registers; keeps the read_data words still owed
	class flash_mirror;
		bit [7:0]   cells [STORE_BYTES];
		logic [1:0] stage;
		logic [1:0] pending;
		bit         id_on;
		bit         bank;
		bit         dual;
		bit [7:0]   man_id;
		bit [7:0]   dev_id;
		bit [7:0]   awaited [$];
		int         mismatches;
		int         checked;
		int         reads;
		int         writes;
		int         programs;
		int         bank_moves;
		int         id_reads;
		int         sector_erases;
		int         chip_erases;

		function new();
			foreach (cells[i])
				cells[i] = ERASED;
			stage = STG_READY;
			pending = OP_NONE;
			id_on = 1'b0;
			bank = 1'b0;
			dual = 1'b0;
			man_id = MAN_ID_RST;
			dev_id = DEV_ID_RST;
		endfunction

		function int unsigned slot(int unsigned a);
			return (int'(bank) * BANK_BYTES + a) % STORE_BYTES;
		endfunction

		function void clear_sector(int unsigned a);
			int unsigned base;
			base = a & 32'hffff & ~(SECTOR_BYTES - 1);
			for (int i = 0; i < SECTOR_BYTES; i++)
				cells[slot(base + i)] = ERASED;
			sector_erases++;
		endfunction

		function void run_pending(int unsigned a, bit [7:0] d);
			case (pending)
				OP_BANK: begin
					if (a == 0) begin
						bank = dual ? d[0] : 1'b0;
						pending = OP_NONE;
						bank_moves++;
					end
				end
				OP_PROGRAM: begin
					cells[slot(a)] = d;
					pending = OP_NONE;
					programs++;
				end
				OP_ERASE: begin
					if (d == CMD_SEC_ERS && stage == STG_TWO) begin
						clear_sector(a);
						pending = OP_NONE;
						stage = STG_READY;
					end
				end
				default: ;
			endcase
		endfunction

		function void run_command(int unsigned a, bit [7:0] d);
			stage = STG_READY;
			case (d)
				CMD_ID_ON: id_on = 1'b1;
				CMD_ID_OFF: id_on = 1'b0;
				CMD_BANK: pending = OP_BANK;
				CMD_ERASE: pending = OP_ERASE;
				CMD_PROGRAM: pending = OP_PROGRAM;
				CMD_CHIP_ERS: begin
					if (pending == OP_ERASE) begin
						foreach (cells[i])
							cells[i] = ERASED;
						pending = OP_NONE;
						chip_erases++;
					end else begin
						stage = STG_TWO;
					end
				end
				CMD_SEC_ERS: begin
					clear_sector(a);
					pending = OP_NONE;
				end
				default: ;
			endcase
		endfunction

		function void note_access(bit c, bit [15:0] a, bit [7:0] d);
			if (c == ACC_WRITE) begin
				writes++;
				if (a == ADDR_UNLOCK1 && stage == STG_READY && d == DATA_UNLOCK1)
					stage = STG_ONE;
				else if (a == ADDR_UNLOCK1 && stage == STG_TWO)
					run_command(a, d);
				else if (a == ADDR_UNLOCK2 && stage == STG_ONE && d == DATA_UNLOCK2)
					stage = STG_TWO;
				else
					run_pending(a, d);
				awaited.push_back(8'h00);
			end else begin
				reads++;
				if (id_on && a < 2) begin
					id_reads++;
					awaited.push_back(a == 0 ? man_id : dev_id);
				end else begin
					awaited.push_back(cells[slot(a)]);
				end
			end
		endfunction

		// which wipe a write would start in the present state
		function int wipe_of(bit [15:0] a, bit [7:0] d);
			if (a == ADDR_UNLOCK1 && stage == STG_READY && d == DATA_UNLOCK1)
				return NO_WIPE;
			if (a == ADDR_UNLOCK1 && stage == STG_TWO) begin
				if (d == CMD_CHIP_ERS && pending == OP_ERASE)
					return CHIP_WIPE;
				return (d == CMD_SEC_ERS) ? SECTOR_WIPE : NO_WIPE;
			end
			if (a == ADDR_UNLOCK2 && stage == STG_ONE && d == DATA_UNLOCK2)
				return NO_WIPE;
			if (pending == OP_ERASE && d == CMD_SEC_ERS && stage == STG_TWO)
				return SECTOR_WIPE;
			return NO_WIPE;
		endfunction

		function void set_register(logic [CFG_W-1:0] idx, logic [7:0] v);
			case (idx)
				REG_TWO_BANKS: dual = v[0];
				REG_MAN_ID: man_id = v;
				REG_DEV_ID: dev_id = v;
				default: ;
			endcase
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void check_read(logic [7:0] got);
			logic [7:0] want;
			checked++;
			if (awaited.size() == 0) begin
				flag($sformatf("read_data word %02h with nothing outstanding", got));
			end else begin
				want = awaited.pop_front();
				if (got !== want)
					flag($sformatf("read_data expected %02h, got %02h", want, got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fscc_req_if req_bus ();
	fscc_rsp_if rsp_bus ();
	fscc_cfg_if cfg_bus ();

	flash_save_command_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	flash_mirror mirror;

	// idling odds per cycle, in percent
	int send_idle_pct = 0;
	int stall_pct = 0;

	// long hold-off: asked by the stimulus, counted by the receiver
	bit hold_asked = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;

	// wipe budget keeps the run length bounded
	int sector_wipes_left = 24;
	int chip_wipes_left = 2;

	// accesses accepted so far
	int sent = 0;

	always #2 clk = ~clk;

	// sample every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				mirror.set_register(cfg_bus.index, cfg_bus.data);
			if (req_bus.valid && req_bus.ready)
				mirror.note_access(req_bus.command, req_bus.address, req_bus.write_data);
			if (rsp_bus.valid && rsp_bus.ready)
				mirror.check_read(rsp_bus.read_data);
		end
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// one bus access; called and returns at a falling edge, valid left high
	task automatic access(bit c, bit [15:0] a, bit [7:0] d);
		int wipe;
		// past the budget, turn a wiping byte into a harmless one
		if (c == ACC_WRITE) begin
			wipe = mirror.wipe_of(a, d);
			if (wipe == CHIP_WIPE) begin
				if (chip_wipes_left == 0)
					d ^= 8'h01;
				else
					chip_wipes_left--;
			end else if (wipe == SECTOR_WIPE) begin
				if (sector_wipes_left == 0)
					d ^= 8'h01;
				else
					sector_wipes_left--;
			end
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= c;
		req_bus.address <= a;
		req_bus.write_data <= d;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic unlock_with(bit [7:0] cmd);
		access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
		access(ACC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
		access(ACC_WRITE, ADDR_UNLOCK1, cmd);
	endtask

	// a read is only taken once any erase is over; then drain and let it rest
	task automatic settle();
		access(ACC_READ, 16'($urandom), 8'($urandom));
		req_bus.valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// drives one register word, leaves valid high for the caller to drop
	task automatic put_register(logic [CFG_W-1:0] idx, logic [7:0] v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= v;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(bit dual, bit [7:0] man, bit [7:0] dev);
		settle();
		put_register(REG_TWO_BANKS, {7'd0, dual});
		put_register(REG_MAN_ID, man);
		put_register(REG_DEV_ID, dev);
		cfg_bus.valid <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// addresses lean on a few hot spots so reads see programmed bytes
	function automatic bit [15:0] pick_address();
		case ($urandom_range(0, 5))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(0, 31));
			3: return 16'hffe0 | 16'($urandom_range(0, 31));
			4: return 16'h5540 | 16'($urandom_range(0, 31));
			default: return $urandom_range(0, 1) ? ADDR_UNLOCK1 : ADDR_UNLOCK2;
		endcase
	endfunction

	function automatic bit [7:0] pick_command();
		case ($urandom_range(0, 7))
			0: return CMD_ID_ON;
			1: return CMD_ID_OFF;
			2: return CMD_BANK;
			3: return CMD_ERASE;
			4: return CMD_CHIP_ERS;
			5: return CMD_SEC_ERS;
			6: return CMD_PROGRAM;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly well-formed command sequences with random content, some noise
	task automatic random_burst();
		bit [15:0] a;
		bit [7:0]  d;
		a = pick_address();
		d = 8'($urandom);
		case ($urandom_range(0, 11))
			0, 1: begin
				// byte program and read back
				unlock_with(CMD_PROGRAM);
				access(ACC_WRITE, a, d);
				access(ACC_READ, a, 8'($urandom));
			end
			2: begin
				// bank select, sometimes a miss at a nonzero address first
				unlock_with(CMD_BANK);
				if ($urandom_range(0, 2) == 0)
					access(ACC_WRITE, a, d);
				access(ACC_WRITE, 16'h0000, 8'($urandom));
			end
			3: begin
				unlock_with($urandom_range(0, 1) ? CMD_ID_ON : CMD_ID_OFF);
				access(ACC_READ, 16'($urandom_range(0, 2)), 8'($urandom));
				access(ACC_READ, 16'($urandom_range(0, 1)), 8'($urandom));
			end
			4: begin
				// armed erase, then a chip erase or a sector erase
				unlock_with(CMD_ERASE);
				if ($urandom_range(0, 7) == 0) begin
					unlock_with(CMD_CHIP_ERS);
				end else begin
					access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
					access(ACC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
					access(ACC_WRITE, $urandom_range(0, 1) ? a : ADDR_UNLOCK1, CMD_SEC_ERS);
				end
				access(ACC_READ, a, 8'($urandom));
			end
			5, 6: begin
				repeat ($urandom_range(1, 4))
					access(ACC_READ, pick_address(), 8'($urandom));
			end
			7: unlock_with(pick_command());
			8: begin
				// pure noise over the whole field ranges
				repeat ($urandom_range(1, 3))
					access(1'($urandom), 16'($urandom), 8'($urandom));
			end
			9: begin
				// broken unlock: first byte then something else
				access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
				case ($urandom_range(0, 2))
					0: access(ACC_WRITE, a, d);
					1: access(ACC_WRITE, a, DATA_UNLOCK2);
					default: access(ACC_WRITE, ADDR_UNLOCK2, d);
				endcase
			end
			10: begin
				// full unlock then a write away from the command address
				access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
				access(ACC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
				access(ACC_WRITE, a, $urandom_range(0, 1) ? CMD_SEC_ERS : d);
			end
			default: access(ACC_WRITE, ADDR_UNLOCK1, d);
		endcase
	endtask

	// stimulus
	initial begin
		int target;
		req_bus.valid = 1'b0;
		req_bus.command = ACC_READ;
		req_bus.address = '0;
		req_bus.write_data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_TWO_BANKS;
		cfg_bus.data = '0;
		arst_n = 1'b0;
		mirror = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, two banks and extreme id bytes
		configure(1'b1, 8'h00, 8'hff);
		unlock_with(CMD_ID_ON);
		access(ACC_READ, 16'h0000, 8'hff);
		access(ACC_READ, 16'h0001, 8'h00);
		// stray write at stage one runs the armed program, stage stays one
		unlock_with(CMD_PROGRAM);
		access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
		access(ACC_WRITE, 16'hffff, 8'h00);
		access(ACC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
		access(ACC_WRITE, ADDR_UNLOCK1, CMD_BANK);
		access(ACC_WRITE, 16'h0000, 8'h01);
		// non-0xaa byte at the unlock address in ready programs it
		unlock_with(CMD_PROGRAM);
		access(ACC_WRITE, ADDR_UNLOCK1, 8'h12);
		access(ACC_READ, ADDR_UNLOCK1, 8'hff);
		// sector erase command itself wipes sector 0x5000 of bank 1
		unlock_with(CMD_SEC_ERS);
		access(ACC_READ, ADDR_UNLOCK1, 8'h00);

		// directed, single bank with bank 1 still selected
		configure(1'b0, MAN_ID_RST, DEV_ID_RST);
		access(ACC_READ, 16'hffff, 8'h5a);
		// chip erase with nothing armed leaves the stage at two
		access(ACC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
		access(ACC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
		access(ACC_WRITE, ADDR_UNLOCK1, CMD_CHIP_ERS);
		// so an unknown byte lands as a command and drops back to ready
		access(ACC_WRITE, ADDR_UNLOCK1, 8'hc3);
		unlock_with(CMD_ID_OFF);
		access(ACC_READ, 16'h0001, 8'hff);
		// real chip erase over both banks
		unlock_with(CMD_ERASE);
		unlock_with(CMD_CHIP_ERS);
		access(ACC_READ, 16'hffff, 8'h00);

		// random phases: no idling, sender idle, receiver stalls, both light
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: configure(1'b1, 8'hff, 8'h00);
				1: configure(1'b0, 8'($urandom), 8'($urandom));
				2: configure(1'b1, 8'($urandom), 8'($urandom));
				default: configure(1'($urandom), 8'($urandom), 8'($urandom));
			endcase
			send_idle_pct = (ph == 1) ? 61 : (ph == 3) ? 10 : 0;
			stall_pct = (ph == 2) ? 61 : (ph == 3) ? 10 : 0;
			// receiver holds off while the sender keeps pushing
			if (ph == 0)
				hold_asked = 1'b1;
			target = sent + PHASE_ACCESSES;
			while (sent < target)
				random_burst();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		settle();
		$display("covered %0d accesses: %0d reads (%0d identify), %0d writes, %0d programs",
			sent, mirror.reads, mirror.id_reads, mirror.writes, mirror.programs);
		$display("  %0d bank selects, %0d sector erases, %0d chip erases, %0d words checked",
			mirror.bank_moves, mirror.sector_erases, mirror.chip_erases, mirror.checked);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hang guard, well past the slowest correct run
	initial begin
		#16000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
